### hw/rtl/sat_pkg.sv
// ---------------------------------------------------------------------------
// Station address table package
// Shared types, codes and sizes for the compacting station table.
// ---------------------------------------------------------------------------
package sat_pkg;

  // Table depth; valid range 1 to 16
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DEL    = 2'd1,
    CMD_SET_IP = 2'd2,
    CMD_READ   = 2'd3
  } sat_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } sat_status_t;

  // Operation broadcast to the row of cells
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LOAD = 2'd1,
    OP_SET  = 2'd2,
    OP_DEL  = 2'd3
  } sat_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2,
    S_RD   = 2'd3
  } sat_state_t;

  typedef struct packed {
    sat_cmd_t           command;
    logic [MAC_W-1:0]   station_mac;
    logic [IP_W-1:0]    station_ip;
    logic [3:0]         read_slot;
  } sat_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic               entry_valid;
    logic [MAC_W-1:0]   entry_mac;
    logic [IP_W-1:0]    entry_ip;
    logic [4:0]         station_count;
  } sat_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
  } sat_entry_t;

  // Control from the row decoder to one cell
  typedef struct packed {
    logic load;
    logic set_ip;
    logic shift;
  } sat_cell_ctl_t;

  // Control from the sequencer to the row
  typedef struct packed {
    sat_op_t          op;
    logic [IDX_W-1:0] idx;
  } sat_row_ctl_t;

endpackage

### hw/rtl/station_address_table.sv
// ---------------------------------------------------------------------------
// Station address table
// Compacted table of stations (MAC and IPv4 address) with add, delete,
// set address and read commands.
// ---------------------------------------------------------------------------
// Each request passes through the sequencer's compare, update and read-back
// steps, and its response is loaded into the output register at the end of
// the read-back step. The compare step checks the MAC against every cell in
// parallel. The update step changes the row of cells: append, address write,
// or compaction shift on delete. The read-back step reads the reported slot
// into the output register. The idle step is the one in which the next
// request is accepted. The sequencer takes the next request once the previous
// one has left the read-back step, so a request follows while an earlier
// response still waits on out_ready; a stalled output holds the read-back
// step. Reset clears every cell's valid flag at once; no clearing pass runs.
module station_address_table
  import sat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sat_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output sat_rsp_t out_rsp
);

  sat_state_t         state_r, state_nxt;
  sat_req_t           req_r, req_nxt;
  logic [ENTRIES-1:0] hit_r, hit_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  sat_status_t        status_r, status_nxt;
  logic               ok_r, ok_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  sat_rsp_t           out_rsp_r, out_rsp_nxt;

  sat_row_ctl_t       row_ctl;
  sat_entry_t         ents [ENTRIES];
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] valid_vec;
  logic [IDX_W-1:0]   hit_idx;
  logic               hit_any;
  logic               full;
  logic               rd_ok;
  logic               out_free;
  sat_entry_t         rd_ent;
  logic               has;

  sat_row u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (row_ctl),
    .key_mac (req_r.station_mac),
    .new_ip  (req_r.station_ip),
    .ents    (ents),
    .hit     (hit)
  );

  // Encode the matching cell; occupied cells hold distinct MACs
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_r;
  assign full     = (count_r == CNT_W'(ENTRIES));
  assign rd_ok    = (32'(req_r.read_slot) < 32'(ENTRIES));
  assign out_free = !out_valid_r || out_ready;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_vld
    assign valid_vec[i] = ents[i].valid;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_RD;
      S_RD:    if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: row control and report decision
  always_comb begin
    in_ready    = 1'b0;
    row_ctl.op  = OP_NONE;
    row_ctl.idx = hit_idx;
    status_nxt  = status_r;
    ok_nxt      = ok_r;
    slot_nxt    = slot_r;
    count_nxt   = count_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_UPD: begin
        status_nxt = ST_DONE;
        ok_nxt     = 1'b1;
        slot_nxt   = hit_idx;
        case (req_r.command)
          CMD_ADD: begin
            if (!hit_any) begin
              if (full) begin
                status_nxt = ST_FULL;
                ok_nxt     = 1'b0;
              end else begin
                row_ctl.op  = OP_LOAD;
                row_ctl.idx = IDX_W'(count_r);
                slot_nxt    = IDX_W'(count_r);
                count_nxt   = count_r + CNT_W'(1);
              end
            end
          end
          CMD_DEL: begin
            if (hit_any) begin
              row_ctl.op = OP_DEL;
              count_nxt  = count_r - CNT_W'(1);
            end else begin
              status_nxt = ST_NOT_FOUND;
              ok_nxt     = 1'b0;
            end
          end
          CMD_SET_IP: begin
            if (hit_any) begin
              row_ctl.op = OP_SET;
            end else begin
              status_nxt = ST_NOT_FOUND;
              ok_nxt     = 1'b0;
            end
          end
          default: begin
            if (rd_ok) begin
              slot_nxt = IDX_W'(req_r.read_slot);
            end else begin
              status_nxt = ST_NOT_FOUND;
              ok_nxt     = 1'b0;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Capture request and match vector
  assign req_nxt = (state_r == S_IDLE && in_valid) ? in_req : req_r;
  assign hit_nxt = (state_r == S_CMP) ? hit : hit_r;

  // Read back the reported slot and build the response
  assign rd_ent = ents[slot_r];
  assign has    = ok_r && rd_ent.valid;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    if (state_r == S_RD && out_free) begin
      out_valid_nxt             = 1'b1;
      out_rsp_nxt.status        = status_r;
      out_rsp_nxt.slot_index    = ok_r ? 4'(slot_r) : 4'd0;
      out_rsp_nxt.entry_valid   = has;
      out_rsp_nxt.entry_mac     = has ? rd_ent.mac : '0;
      out_rsp_nxt.entry_ip      = has ? rd_ent.ip : '0;
      out_rsp_nxt.station_count = 5'(count_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    ok_r      <= ok_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Occupied cells never share a MAC
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one cell matched the key");

  // Occupied cells equal the station count
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(count_r))
    else $error("valid cells disagree with station count");

  // Compaction keeps occupied cells at the bottom of the row
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
    else $error("gap in occupied cells");

  // A delete removes exactly one station
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && row_ctl.op == OP_DEL) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not drop the count by one");

endmodule

### hw/rtl/sat_cell.sv
// ---------------------------------------------------------------------------
// Station table cell
// Holds one station, compares it against the search key and takes its
// upper neighbor's contents when the row compacts after a delete.
// ---------------------------------------------------------------------------
module sat_cell
  import sat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sat_cell_ctl_t    ctl,
  input  logic [MAC_W-1:0] key_mac,
  input  logic [IP_W-1:0]  new_ip,
  input  sat_entry_t       nbr,
  output sat_entry_t       ent,
  output logic             match
);

  logic             valid_r, valid_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic [IP_W-1:0]  ip_r, ip_nxt;

  // Select next contents: shift wins, then append, then address write
  always_comb begin
    valid_nxt = valid_r;
    mac_nxt   = mac_r;
    ip_nxt    = ip_r;
    if (ctl.shift) begin
      valid_nxt = nbr.valid;
      mac_nxt   = nbr.mac;
      ip_nxt    = nbr.ip;
    end else if (ctl.load) begin
      valid_nxt = 1'b1;
      mac_nxt   = key_mac;
      ip_nxt    = '0;
    end else if (ctl.set_ip) begin
      ip_nxt    = new_ip;
    end
  end

  // Clear the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the station payload
  always_ff @(posedge clk) begin
    mac_r <= mac_nxt;
    ip_r  <= ip_nxt;
  end

  // Compare only occupied cells
  assign match     = valid_r && (mac_r == key_mac);
  assign ent.valid = valid_r;
  assign ent.mac   = mac_r;
  assign ent.ip    = ip_r;

endmodule

### hw/rtl/sat_row.sv
// ---------------------------------------------------------------------------
// Station table row
// Chains the cells, each fed by its upper neighbor, and decodes the
// broadcast operation into per-cell load, address write and shift.
// ---------------------------------------------------------------------------
module sat_row
  import sat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sat_row_ctl_t       ctl,
  input  logic [MAC_W-1:0]   key_mac,
  input  logic [IP_W-1:0]    new_ip,
  output sat_entry_t         ents [ENTRIES],
  output logic [ENTRIES-1:0] hit
);

  sat_entry_t nbrs [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sat_cell_ctl_t cctl;

    // Decode the cell's share of the operation
    always_comb begin
      cctl.load   = (ctl.op == OP_LOAD) && (ctl.idx == IDX_W'(i));
      cctl.set_ip = (ctl.op == OP_SET)  && (ctl.idx == IDX_W'(i));
      cctl.shift  = (ctl.op == OP_DEL)  && (IDX_W'(i) >= ctl.idx);
    end

    // Feed from the upper neighbor; the top cell takes an empty entry
    if (i == ENTRIES - 1) begin : g_top
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = ents[i+1];
    end

    sat_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cctl),
      .key_mac (key_mac),
      .new_ip  (new_ip),
      .nbr     (nbrs[i]),
      .ent     (ents[i]),
      .match   (hit[i])
    );
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Station address table testbench
// Sends add, delete, set address and read requests through the valid/ready
// input and checks every response against a local model of the compacted
// table. Both sides idle at random: the sender in bursts, the receiver on
// its own stall pattern.
// ---------------------------------------------------------------------------
module tb;
  import sat_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sat_req_t in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sat_rsp_t out_rsp;

  // Local copy of the station table
  logic [MAC_W-1:0] mac_tbl [ENTRIES];
  logic [IP_W-1:0]  ip_tbl  [ENTRIES];
  int               station_count;

  sat_rsp_t expected_rsp_q [$];
  int       error_count;
  int       sent_count;
  int       burst_left;
  int       ready_tick;
  int       ready_mode;

  station_address_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Apply one request to the table model and return the response it causes
  function automatic sat_rsp_t predict_station_cmd(input sat_req_t r);
    sat_rsp_t    rsp;
    sat_status_t status;
    int          hit;
    int          slot;
    logic        ok;
    logic        has;
    hit    = -1;
    slot   = 0;
    status = ST_DONE;
    for (int i = 0; i < station_count; i++) begin
      if (hit < 0 && mac_tbl[i] == r.station_mac) hit = i;
    end
    case (r.command)
      CMD_ADD: begin
        if (hit >= 0) begin
          slot = hit;
        end else if (station_count < ENTRIES) begin
          mac_tbl[station_count] = r.station_mac;
          ip_tbl[station_count]  = '0;
          slot = station_count;
          station_count++;
        end else begin
          status = ST_FULL;
        end
      end
      CMD_DEL: begin
        if (hit < 0) begin
          status = ST_NOT_FOUND;
        end else begin
          // compact: shift later stations down, clear the freed slot
          for (int i = hit; i < station_count - 1; i++) begin
            mac_tbl[i] = mac_tbl[i+1];
            ip_tbl[i]  = ip_tbl[i+1];
          end
          mac_tbl[station_count-1] = '0;
          ip_tbl[station_count-1]  = '0;
          station_count--;
          slot = hit;
        end
      end
      CMD_SET_IP: begin
        if (hit < 0) begin
          status = ST_NOT_FOUND;
        end else begin
          ip_tbl[hit] = r.station_ip;
          slot = hit;
        end
      end
      default: begin
        if (int'(r.read_slot) < ENTRIES) slot = r.read_slot;
        else status = ST_NOT_FOUND;
      end
    endcase
    ok  = (status == ST_DONE) && (slot < ENTRIES);
    has = ok && (slot < station_count);
    rsp.status        = status;
    rsp.slot_index    = ok ? slot[3:0] : 4'd0;
    rsp.entry_valid   = has;
    rsp.entry_mac     = has ? mac_tbl[slot] : '0;
    rsp.entry_ip      = has ? ip_tbl[slot] : '0;
    rsp.station_count = station_count[4:0];
    return rsp;
  endfunction

  function automatic sat_req_t make_req(input sat_cmd_t c, input logic [MAC_W-1:0] m,
                                        input logic [IP_W-1:0] ip, input logic [3:0] s);
    sat_req_t r;
    r.command     = c;
    r.station_mac = m;
    r.station_ip  = ip;
    r.read_slot   = s;
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  // Send one request; idle between bursts, record the expected response
  task automatic send_request(input sat_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsp_q.push_back(predict_station_cmd(r));
    sent_count++;
  endtask

  // Receiver: drive the stall pattern and check each response
  always @(posedge clk) begin
    sat_rsp_t exp_rsp;
    string    diffs;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("ERROR: unexpected response %p", out_rsp);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          diffs = "";
          if (out_rsp.status != exp_rsp.status) diffs = {diffs, " status"};
          if (out_rsp.slot_index != exp_rsp.slot_index) diffs = {diffs, " slot_index"};
          if (out_rsp.entry_valid != exp_rsp.entry_valid) diffs = {diffs, " entry_valid"};
          if (out_rsp.entry_mac != exp_rsp.entry_mac) diffs = {diffs, " entry_mac"};
          if (out_rsp.entry_ip != exp_rsp.entry_ip) diffs = {diffs, " entry_ip"};
          if (out_rsp.station_count != exp_rsp.station_count)
            diffs = {diffs, " station_count"};
          if (diffs != "") begin
            error_count++;
            if (error_count <= 10) begin
              $display("ERROR: mismatch in%s", diffs);
              $display("  expected %p", exp_rsp);
              $display("  actual   %p", out_rsp);
            end
          end
        end
      end
      // periodically pick a random stall mode: no stall, random, heavy
      ready_tick++;
      if (ready_tick % 64 == 0) ready_mode = $urandom_range(0, 2);
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Empty table, full table, field extremes, compaction at both ends
  task automatic test_directed_table_edges();
    logic [MAC_W-1:0] ones_mac;
    ones_mac = '1;
    send_request(make_req(CMD_READ, '0, '0, 4'd0));
    send_request(make_req(CMD_DEL, '0, '0, 4'd0));
    send_request(make_req(CMD_SET_IP, ones_mac, '1, 4'd0));
    send_request(make_req(CMD_ADD, '0, '1, 4'd15));
    send_request(make_req(CMD_ADD, ones_mac, '0, 4'd0));
    send_request(make_req(CMD_ADD, '0, '0, 4'd0));
    send_request(make_req(CMD_SET_IP, ones_mac, '1, 4'd0));
    for (int i = 2; i < ENTRIES; i++) begin
      send_request(make_req(CMD_ADD, {16'hA5C3, 32'(i)}, 32'(i), 4'(i)));
    end
    send_request(make_req(CMD_ADD, 48'h0123_4567_89AB, '0, 4'd0));
    send_request(make_req(CMD_ADD, ones_mac, '0, 4'd0));
    send_request(make_req(CMD_READ, '0, '0, 4'd15));
    send_request(make_req(CMD_DEL, '0, '0, 4'd0));
    send_request(make_req(CMD_DEL, {16'hA5C3, 32'(ENTRIES - 1)}, '0, 4'd0));
    send_request(make_req(CMD_READ, '0, '0, 4'd15));
    send_request(make_req(CMD_DEL, {16'hA5C3, 32'd7}, '0, 4'd0));
    send_request(make_req(CMD_SET_IP, {16'hA5C3, 32'd9}, '0, 4'd0));
    send_request(make_req(CMD_READ, '0, '0, 4'd7));
  endtask

  // Weighted commands on a small pool of stations so hits are common
  task automatic test_random_churn(input int n_req);
    logic [MAC_W-1:0] pool [20];
    int               pick;
    sat_cmd_t         c;
    foreach (pool[i]) pool[i] = rand_mac();
    repeat (n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      c = CMD_ADD;
      else if (pick < 60) c = CMD_DEL;
      else if (pick < 80) c = CMD_SET_IP;
      else                c = CMD_READ;
      send_request(make_req(c, pool[$urandom_range(0, 19)], $urandom(),
                            4'($urandom_range(0, 15))));
    end
  endtask

  // Fully random fields: mostly misses, occasional known station
  task automatic test_random_noise(input int n_req);
    logic [MAC_W-1:0] m;
    repeat (n_req) begin
      if (station_count > 0 && $urandom_range(0, 3) == 0)
        m = mac_tbl[$urandom_range(0, station_count - 1)];
      else
        m = rand_mac();
      send_request(make_req(sat_cmd_t'($urandom_range(0, 3)), m, $urandom(),
                            4'($urandom_range(0, 15))));
    end
  endtask

  // Rounds of filling the table with fresh stations, then deleting them all
  task automatic test_fill_and_drain(input int n_req);
    logic [MAC_W-1:0] live [$];
    logic [MAC_W-1:0] m;
    int               target;
    int               n;
    int               k;
    target = sent_count + n_req;
    // drain what earlier tests left in the table, in random order
    while (station_count > 0) begin
      m = mac_tbl[$urandom_range(0, station_count - 1)];
      send_request(make_req(CMD_DEL, m, $urandom(), 4'($urandom_range(0, 15))));
    end
    while (sent_count < target) begin
      n = ($urandom_range(0, 4) == 0) ? ENTRIES + $urandom_range(0, 3)
                                      : $urandom_range(1, 8);
      live.delete();
      for (int i = 0; i < n; i++) begin
        m = rand_mac();
        if (live.size() < ENTRIES) live.push_back(m);
        send_request(make_req(CMD_ADD, m, $urandom(), 4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1) == 1)
          send_request(make_req(CMD_SET_IP, m, $urandom(), 4'($urandom_range(0, 15))));
        if ($urandom_range(0, 3) == 0)
          send_request(make_req(CMD_READ, rand_mac(), $urandom(),
                                4'($urandom_range(0, 15))));
      end
      while (live.size() > 0) begin
        k = $urandom_range(0, live.size() - 1);
        send_request(make_req(CMD_DEL, live[k], $urandom(), 4'($urandom_range(0, 15))));
        live.delete(k);
        if ($urandom_range(0, 4) == 0)
          send_request(make_req(CMD_DEL, rand_mac(), $urandom(), 4'($urandom_range(0, 15))));
        if ($urandom_range(0, 3) == 0)
          send_request(make_req(CMD_READ, '0, '0, 4'($urandom_range(0, 15))));
      end
    end
  endtask

  initial begin
    foreach (mac_tbl[i]) begin
      mac_tbl[i] = '0;
      ip_tbl[i]  = '0;
    end
    station_count = 0;
    error_count   = 0;
    sent_count    = 0;
    burst_left    = 0;
    ready_tick    = 0;
    ready_mode    = 0;

    // hold reset, then release at a clock edge
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_table_edges();
    test_random_churn(700);
    test_random_noise(350);
    test_fill_and_drain(600);
    in_valid <= 1'b0;

    // drain outstanding responses, then let the pipeline settle
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### station_address_table.f
hw/rtl/sat_pkg.sv
hw/rtl/sat_cell.sv
hw/rtl/sat_row.sv
hw/rtl/station_address_table.sv
test/tb.sv
